FILE: rtl/ryuv_pkg.sv
`timescale 1ns / 1ps

package ryuv_pkg;

  localparam int NUM_PIX = 4;
  localparam logic [7:0] ALPHA_THRESHOLD_RESET = 8'd128;

  // Widths of the block-level sums and counts.
  localparam int CNT_W = 3;
  localparam int CSUM_W = 10;

  // Reciprocal of three in 11 fractional bits; exact floor for sums below 1024.
  localparam logic [9:0] RECIP3 = 10'd683;

  typedef struct packed {
    logic       in_patch;
    logic       opaque;
    logic [7:0] luma;
    logic [7:0] cb;
    logic [7:0] cr;
  } lane_res_t;

  typedef struct packed {
    logic [7:0] luma_top_left;
    logic [7:0] luma_top_right;
    logic [7:0] luma_bottom_left;
    logic [7:0] luma_bottom_right;
    logic [3:0] luma_opaque;
    logic       chroma_opaque;
    logic [7:0] chroma_blue;
    logic [7:0] chroma_red;
  } block_res_t;

  // Floor of sum / cnt for cnt in 1..4; the sum never exceeds 240 * cnt.
  function automatic logic [7:0] div_by_count(input logic [CSUM_W-1:0] sum,
                                              input logic [CNT_W-1:0] cnt);
    logic [19:0] prod;
    logic [7:0]  q;
    prod = 20'(sum) * 20'(RECIP3);
    case (cnt)
      3'd1: q = sum[7:0];
      3'd2: q = sum[8:1];
      3'd3: q = prod[18:11];
      3'd4: q = sum[9:2];
      default: q = 8'd0;
    endcase
    return q;
  endfunction

endpackage

FILE: rtl/ryuv_if.sv
`timescale 1ns / 1ps

interface ryuv_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_top_left;
  logic [31:0] pixel_top_right;
  logic [31:0] pixel_bottom_left;
  logic [31:0] pixel_bottom_right;
  logic [3:0]  inside_patch;

  modport source (
    output valid, pixel_top_left, pixel_top_right, pixel_bottom_left,
           pixel_bottom_right, inside_patch,
    input  ready
  );
  modport sink (
    input  valid, pixel_top_left, pixel_top_right, pixel_bottom_left,
           pixel_bottom_right, inside_patch,
    output ready
  );
endinterface

interface ryuv_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma_top_left;
  logic [7:0] luma_top_right;
  logic [7:0] luma_bottom_left;
  logic [7:0] luma_bottom_right;
  logic [3:0] luma_opaque;
  logic       chroma_opaque;
  logic [7:0] chroma_blue;
  logic [7:0] chroma_red;

  modport source (
    output valid, luma_top_left, luma_top_right, luma_bottom_left,
           luma_bottom_right, luma_opaque, chroma_opaque, chroma_blue, chroma_red,
    input  ready
  );
  modport sink (
    input  valid, luma_top_left, luma_top_right, luma_bottom_left,
           luma_bottom_right, luma_opaque, chroma_opaque, chroma_blue, chroma_red,
    output ready
  );
endinterface

FILE: rtl/rgba_block_to_yuv420_masked.sv
`timescale 1ns / 1ps
// Channel   Direction  Payload
// pixels    in         four RGBA words and the 4-bit patch mask of one 2x2 block
// samples   out        four luma values, opacity bits, one chroma sample
// cfg       in         alpha threshold write (cfg_we, cfg_data)
//
// One block per cycle while samples is ready, through the lane and result registers.
// Four pixel lanes compute luma and chroma in the first stage; the merge stage
// counts, sums and divides the chroma and holds the result register.
// A samples stall holds each full stage; pixels.ready drops only when both are full.
// rst clears the stage valid bits and sets the threshold to 128.

module rgba_block_to_yuv420_masked
  import ryuv_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data,
  ryuv_in_if.sink    pixels,
  ryuv_out_if.source samples
);

  logic [7:0]  alpha_threshold;
  logic        lane_valid;
  logic        res_valid;
  logic        lane_en;
  logic        res_en;
  logic [31:0] pix [NUM_PIX];
  lane_res_t   lanes [NUM_PIX];
  block_res_t  res;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_threshold <= ALPHA_THRESHOLD_RESET;
    end else if (cfg_we) begin
      alpha_threshold <= cfg_data;
    end
  end

  // Advance a stage when its register is empty or drains this cycle.
  assign res_en       = !res_valid || samples.ready;
  assign lane_en      = !lane_valid || res_en;
  assign pixels.ready = lane_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_valid <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (lane_en) begin
        lane_valid <= pixels.valid;
      end
      if (res_en) begin
        res_valid <= lane_valid;
      end
    end
  end

  assign pix[0] = pixels.pixel_top_left;
  assign pix[1] = pixels.pixel_top_right;
  assign pix[2] = pixels.pixel_bottom_left;
  assign pix[3] = pixels.pixel_bottom_right;

  for (genvar k = 0; k < NUM_PIX; k++) begin : g_lane
    ryuv_lane u_lane (
      .clk             (clk),
      .en              (lane_en),
      .pixel           (pix[k]),
      .in_patch        (pixels.inside_patch[k]),
      .alpha_threshold (alpha_threshold),
      .res             (lanes[k])
    );
  end

  ryuv_merge u_merge (
    .clk   (clk),
    .en    (res_en),
    .lanes (lanes),
    .res   (res)
  );

  assign samples.valid             = res_valid;
  assign samples.luma_top_left     = res.luma_top_left;
  assign samples.luma_top_right    = res.luma_top_right;
  assign samples.luma_bottom_left  = res.luma_bottom_left;
  assign samples.luma_bottom_right = res.luma_bottom_right;
  assign samples.luma_opaque       = res.luma_opaque;
  assign samples.chroma_opaque     = res.chroma_opaque;
  assign samples.chroma_blue       = res.chroma_blue;
  assign samples.chroma_red        = res.chroma_red;

  a_chroma_needs_opaque: assert property (@(posedge clk) disable iff (rst)
    samples.valid && samples.chroma_opaque |-> samples.luma_opaque != 4'd0)
    else $error("chroma opaque with no opaque pixel");

  a_chroma_zero: assert property (@(posedge clk) disable iff (rst)
    samples.valid && !samples.chroma_opaque
      |-> samples.chroma_blue == 8'd0 && samples.chroma_red == 8'd0)
    else $error("chroma not cleared");

  a_luma_masked: assert property (@(posedge clk) disable iff (rst)
    samples.valid && !samples.luma_opaque[0] |-> samples.luma_top_left == 8'd0)
    else $error("luma of non-opaque pixel not zero");

  a_luma_range: assert property (@(posedge clk) disable iff (rst)
    samples.valid && samples.luma_opaque[3]
      |-> samples.luma_bottom_right >= 8'd16 && samples.luma_bottom_right <= 8'd235)
    else $error("luma out of limited range");

  a_stall_holds_stage: assert property (@(posedge clk) disable iff (rst)
    lane_valid && res_valid && !samples.ready |=> lane_valid && res_valid)
    else $error("stage lost under stall");

endmodule

FILE: rtl/ryuv_lane.sv
`timescale 1ns / 1ps

module ryuv_lane
  import ryuv_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] pixel,
  input  logic        in_patch,
  input  logic [7:0]  alpha_threshold,
  output lane_res_t   res
);

  logic [7:0]         red;
  logic [7:0]         green;
  logic [7:0]         blue;
  logic [7:0]         alpha;
  logic               opaque;
  logic [16:0]        y_sum;
  logic [16:0]        y_full;
  logic signed [17:0] u_sum;
  logic signed [17:0] v_sum;
  logic signed [17:0] u_full;
  logic signed [17:0] v_full;
  lane_res_t          res_next;

  assign red   = pixel[7:0];
  assign green = pixel[15:8];
  assign blue  = pixel[23:16];
  assign alpha = pixel[31:24];

  assign opaque = in_patch && (alpha >= alpha_threshold);

  assign y_sum = 17'd66 * 17'(red) + 17'd129 * 17'(green) + 17'd25 * 17'(blue) + 17'd128;
  assign u_sum = 18'sd112 * $signed(18'(blue)) - 18'sd38 * $signed(18'(red))
               - 18'sd74 * $signed(18'(green)) + 18'sd128;
  assign v_sum = 18'sd112 * $signed(18'(red)) - 18'sd94 * $signed(18'(green))
               - 18'sd18 * $signed(18'(blue)) + 18'sd128;

  // Arithmetic shift floors the negative sums.
  assign y_full = 17'd16 + (y_sum >> 8);
  assign u_full = 18'sd128 + (u_sum >>> 8);
  assign v_full = 18'sd128 + (v_sum >>> 8);

  always_comb begin
    res_next.in_patch = in_patch;
    res_next.opaque   = opaque;
    res_next.luma     = opaque ? y_full[7:0] : 8'd0;
    res_next.cb       = u_full[7:0];
    res_next.cr       = v_full[7:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= res_next;
    end
  end

endmodule

FILE: rtl/ryuv_merge.sv
`timescale 1ns / 1ps

module ryuv_merge
  import ryuv_pkg::*;
(
  input  logic       clk,
  input  logic       en,
  input  lane_res_t  lanes [NUM_PIX],
  output block_res_t res
);

  logic [CNT_W-1:0]  in_cnt;
  logic [CNT_W-1:0]  cov_cnt;
  logic [CSUM_W-1:0] sum_u;
  logic [CSUM_W-1:0] sum_v;
  logic [3:0]        opaque_bits;
  logic              chroma;
  block_res_t        res_next;

  always_comb begin
    in_cnt  = '0;
    cov_cnt = '0;
    sum_u   = '0;
    sum_v   = '0;
    for (int k = 0; k < NUM_PIX; k++) begin
      opaque_bits[k] = lanes[k].opaque;
      in_cnt  = in_cnt + CNT_W'(lanes[k].in_patch);
      cov_cnt = cov_cnt + CNT_W'(lanes[k].opaque);
      if (lanes[k].opaque) begin
        sum_u = sum_u + CSUM_W'(lanes[k].cb);
        sum_v = sum_v + CSUM_W'(lanes[k].cr);
      end
    end
  end

  assign chroma = (in_cnt != '0) && (cov_cnt != '0)
               && ({cov_cnt, 1'b0} >= {1'b0, in_cnt});

  always_comb begin
    res_next.luma_top_left     = lanes[0].luma;
    res_next.luma_top_right    = lanes[1].luma;
    res_next.luma_bottom_left  = lanes[2].luma;
    res_next.luma_bottom_right = lanes[3].luma;
    res_next.luma_opaque       = opaque_bits;
    res_next.chroma_opaque     = chroma;
    res_next.chroma_blue       = chroma ? div_by_count(sum_u, cov_cnt) : 8'd0;
    res_next.chroma_red        = chroma ? div_by_count(sum_v, cov_cnt) : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= res_next;
    end
  end

endmodule
